@@ sv/voxel_face_culler_core_macros.svh @@
// Assertion macros shared by the voxel face culler checker.
`ifndef VOXEL_FACE_CULLER_CORE_MACROS_SVH
`define VOXEL_FACE_CULLER_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk and disabled while aresetn is low.
`define VFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled while aresetn is low.
`define VFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/vfc_pkg.sv @@
// Shared types and constants of the voxel face culler.
`timescale 1ns / 1ps
`default_nettype none

package vfc_pkg;

    // Stream widths at the top-level ports.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;

    // Fixed field widths.
    localparam int IDX_W    = 14;
    localparam int TYPE_W   = 8;
    localparam int TILE_W   = 8;
    localparam int XY_OUT_W = 4;
    localparam int Z_OUT_W  = 6;
    localparam int TCOL_W   = 4;
    localparam int VCNT_W   = 19;

    localparam int FACE_COUNT     = 6;
    localparam int VERTS_PER_FACE = 4;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        REQ_LOAD_CELL = 2'd0,
        REQ_LOAD_TILE = 2'd1,
        REQ_MESH      = 2'd2,
        REQ_CLEAR     = 2'd3
    } req_t;

    // Face numbering, in the order the neighbours are probed.
    typedef enum logic [2:0] {
        FACE_TOP    = 3'd0,
        FACE_BOTTOM = 3'd1,
        FACE_BACK   = 3'd2,
        FACE_FRONT  = 3'd3,
        FACE_LEFT   = 3'd4,
        FACE_RIGHT  = 3'd5
    } face_t;

endpackage

`default_nettype wire

@@ sv/voxel_face_culler_core.sv @@
// Top level of the voxel face culler: chunk store, tile table and face sequencer.
//
//  Channel  | Direction | tdata                                   | tuser    | tlast
//  ---------+-----------+-----------------------------------------+----------+--------------
//  s_       | in        | cell_index, block_type, opaque,         | req_type | -
//           |           | face_sel, tile_id                       |          |
//  m_       | out       | cell_x, cell_y, cell_z, face, tile_col, | -        | last face of
//           |           | tile_row, first_vertex                  |          | the cell
//
// Loads and counter clears finish while the sequencer stays idle. A mesh item on a
// solid cell walks the sequencer states, then sends each visible face in turn, holding
// while m_tready is low; a mesh of an empty cell ends once the cell is read, and one
// of an index outside the chunk is dropped. The sequence is set by the seven reads of
// the single-port cell store and by the shared divide-by-XY_SIZE unit, used twice.
// Reset is synchronous on aresetn; both stores are not cleared and hold garbage until loaded.
// s_tready is high only while the sequencer is idle; a face waiting in the output register
// does not stop the next item from being taken.
`timescale 1ns / 1ps
`default_nettype none

module voxel_face_culler_core #(
    parameter int XY_SIZE       = 16,
    parameter int Z_SIZE        = 64,
    parameter int TYPE_COUNT    = 256,
    parameter int TILES_PER_ROW = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // cell_index[13:0], block_type[21:14], opaque[22], face_sel[25:23], tile_id[33:26]
    input  wire logic [vfc_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  wire logic [vfc_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // cell_x[3:0], cell_y[7:4], cell_z[13:8], face[16:14], tile_col[20:17],
    // tile_row[24:21], first_vertex[43:25]
    output logic [vfc_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast
);
    import vfc_pkg::*;

    // Geometry and table sizes.
    localparam int CELL_COUNT   = XY_SIZE * XY_SIZE * Z_SIZE;
    localparam int AW           = $clog2(CELL_COUNT);
    localparam int XYW          = $clog2(XY_SIZE);
    localparam int ZW           = $clog2(Z_SIZE);
    localparam int TILE_ENTRIES = TYPE_COUNT * FACE_COUNT;
    localparam int TAW          = $clog2(TILE_ENTRIES);

    // Reciprocal for the divide-by-XY_SIZE unit; the estimate is low by at most one.
    localparam int DIV_SH = AW + XYW + 1;
    localparam int PROD_W = AW + DIV_SH;
    localparam logic [DIV_SH-1:0] XY_RECIP = DIV_SH'((64'd1 << DIV_SH) / XY_SIZE);

    // Reciprocal for splitting a tile number into column and row.
    localparam int TDIV_SH = TILE_W + 7;
    localparam int TPROD_W = TILE_W + TDIV_SH;
    localparam logic [TDIV_SH-1:0] T_RECIP = TDIV_SH'((64'd1 << TDIV_SH) / TILES_PER_ROW);
    localparam logic [TILE_W-1:0]  TPR_MUL = TILE_W'(TILES_PER_ROW);

    localparam logic [AW-1:0]  XY_STEP    = AW'(XY_SIZE);
    localparam logic [AW-1:0]  PLANE_STEP = AW'(XY_SIZE * XY_SIZE);
    localparam logic [AW-1:0]  ROW_STEP   = AW'(1);
    localparam logic [AW:0]    XY_WIDE    = (AW + 1)'(XY_SIZE);
    localparam logic [XYW-1:0] XY_LAST    = XYW'(XY_SIZE - 1);
    localparam logic [ZW-1:0]  Z_LAST     = ZW'(Z_SIZE - 1);
    localparam logic [VCNT_W-1:0] VERT_STEP = VCNT_W'(VERTS_PER_FACE);

    // Sequencer states.
    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_CELL      = 8'b0000_0010,
        ST_DIVX      = 8'b0000_0100,
        ST_DIVY_A    = 8'b0000_1000,
        ST_DIVY_B    = 8'b0001_0000,
        ST_PROBE     = 8'b0010_0000,
        ST_PROBE_END = 8'b0100_0000,
        ST_EMIT      = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Input item fields.
    logic [IDX_W-1:0]  in_idx;
    logic [TYPE_W-1:0] in_btype;
    logic              in_opaque;
    logic [2:0]        in_fsel;
    logic [TILE_W-1:0] in_tid;
    req_t              in_req;
    logic              in_accept;
    logic              in_range;
    logic              type_in_table;

    assign in_idx    = s_tdata[13:0];
    assign in_btype  = s_tdata[21:14];
    assign in_opaque = s_tdata[22];
    assign in_fsel   = s_tdata[25:23];
    assign in_tid    = s_tdata[33:26];
    assign in_req    = req_t'(s_tuser);

    assign s_tready      = aresetn && (state_reg == ST_IDLE);
    assign in_accept     = s_tvalid && s_tready;
    assign in_range      = 32'(in_idx) < CELL_COUNT;
    assign type_in_table = (32'(in_btype) < TYPE_COUNT) && (32'(in_fsel) < FACE_COUNT);

    // Cell being meshed.
    logic [AW-1:0]     idx_reg;
    logic [XYW-1:0]    x_reg;
    logic [XYW-1:0]    y_reg;
    logic [ZW-1:0]     z_reg;
    logic              type_ok_reg;
    logic [TAW-1:0]    tile_base_reg;

    // Shared divider operand and estimate.
    logic [AW-1:0]     div_t_reg;
    logic [AW-1:0]     div_q_reg;

    // Probe pipeline: the read issued last cycle and its face.
    face_t             f_reg;
    face_t             pf_reg;
    logic              pv_reg;
    logic              pout_reg;
    logic [FACE_COUNT-1:0] vis_reg;
    logic [TILE_W-1:0] tile_reg [FACE_COUNT];
    logic [TILE_W-1:0] tq_reg   [FACE_COUNT];

    logic [VCNT_W-1:0] vcnt_reg;

    // Memories and their registered read data.
    logic [TYPE_W:0]   cell_mem [CELL_COUNT];
    logic [TILE_W-1:0] tile_mem [TILE_ENTRIES];
    logic [TYPE_W:0]   cell_rd_reg;
    logic [TILE_W-1:0] tile_rd_reg;

    // Output register.
    logic              m_tvalid_reg;
    logic              m_tlast_reg;
    logic [XY_OUT_W-1:0] m_x_reg;
    logic [XY_OUT_W-1:0] m_y_reg;
    logic [Z_OUT_W-1:0]  m_z_reg;
    face_t               m_face_reg;
    logic [TCOL_W-1:0]   m_col_reg;
    logic [TCOL_W-1:0]   m_row_reg;
    logic [VCNT_W-1:0]   m_fv_reg;

    // Divide-by-XY_SIZE unit: estimate by reciprocal, then one correcting subtract.
    logic [PROD_W-1:0] div_prod;
    logic [AW-1:0]     div_q0;
    logic [AW-1:0]     div_back;
    logic [AW:0]       div_r0;
    logic              div_fix;
    logic [XYW-1:0]    div_rem;
    logic [AW-1:0]     div_quot;

    assign div_prod = PROD_W'(div_t_reg) * PROD_W'(XY_RECIP);
    assign div_q0   = div_prod[DIV_SH +: AW];
    assign div_back = div_q_reg * XY_STEP;
    assign div_r0   = (AW + 1)'(div_t_reg) - (AW + 1)'(div_back);
    assign div_fix  = div_r0 >= XY_WIDE;
    assign div_rem  = XYW'(div_fix ? div_r0 - XY_WIDE : div_r0);
    assign div_quot = div_q_reg + AW'(div_fix);

    // Neighbour address and chunk-boundary test for the face being probed.
    logic [AW-1:0] nb_addr;
    logic          nb_outside;

    always_comb begin
        case (f_reg)
            FACE_TOP: begin
                nb_outside = (z_reg == Z_LAST);
                nb_addr    = idx_reg + PLANE_STEP;
            end
            FACE_BOTTOM: begin
                nb_outside = (z_reg == '0);
                nb_addr    = idx_reg - PLANE_STEP;
            end
            FACE_BACK: begin
                nb_outside = (x_reg == '0);
                nb_addr    = idx_reg - ROW_STEP;
            end
            FACE_FRONT: begin
                nb_outside = (x_reg == XY_LAST);
                nb_addr    = idx_reg + ROW_STEP;
            end
            FACE_LEFT: begin
                nb_outside = (y_reg == '0);
                nb_addr    = idx_reg - XY_STEP;
            end
            FACE_RIGHT: begin
                nb_outside = (y_reg == XY_LAST);
                nb_addr    = idx_reg + XY_STEP;
            end
            default: begin
                nb_outside = 1'b1;
                nb_addr    = idx_reg;
            end
        endcase
    end

    // Memory ports: loads write while idle, the sequencer reads otherwise.
    logic              cell_we;
    logic [AW-1:0]     cell_addr;
    logic              tile_we;
    logic [TAW-1:0]    tile_addr;

    assign cell_we = in_accept && (in_req == REQ_LOAD_CELL) && in_range;
    assign tile_we = in_accept && (in_req == REQ_LOAD_TILE) && type_in_table;

    always_comb begin
        if (state_reg == ST_PROBE) begin
            cell_addr = nb_addr;
        end else if (state_reg == ST_CELL) begin
            cell_addr = idx_reg;
        end else begin
            cell_addr = AW'(in_idx);
        end
    end

    always_comb begin
        if (tile_we) begin
            tile_addr = TAW'(in_btype) * TAW'(FACE_COUNT) + TAW'(in_fsel);
        end else begin
            tile_addr = tile_base_reg + TAW'(f_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cell_we) begin
            cell_mem[cell_addr] <= {in_opaque, in_btype};
        end
        cell_rd_reg <= cell_mem[cell_addr];
    end

    always_ff @(posedge aclk) begin
        if (tile_we) begin
            tile_mem[tile_addr] <= in_tid;
        end
        tile_rd_reg <= tile_mem[tile_addr];
    end

    // Tile returned by the last probe, forced to zero for a type outside the table.
    logic [TILE_W-1:0]  probe_tile;
    logic [TPROD_W-1:0] probe_prod;

    assign probe_tile = type_ok_reg ? tile_rd_reg : '0;
    assign probe_prod = TPROD_W'(probe_tile) * TPROD_W'(T_RECIP);

    // Lowest visible face still to be sent.
    face_t                 emit_f;
    logic [FACE_COUNT-1:0] vis_rest;

    always_comb begin
        emit_f = FACE_TOP;
        for (int i = FACE_COUNT - 1; i >= 0; i--) begin
            if (vis_reg[i]) begin
                emit_f = face_t'(3'(i));
            end
        end
    end

    assign vis_rest = vis_reg & ~(FACE_COUNT'(1) << emit_f);

    // Split of the chosen tile into column and row, finishing the reciprocal estimate.
    logic [TILE_W-1:0] emit_tile;
    logic [TILE_W-1:0] emit_q0;
    logic [TILE_W-1:0] emit_back;
    logic [TILE_W-1:0] emit_r0;
    logic              emit_fix;
    logic [TILE_W-1:0] emit_col;
    logic [TILE_W-1:0] emit_row;
    logic              out_free;
    logic              emit_go;

    assign emit_tile = tile_reg[emit_f];
    assign emit_q0   = tq_reg[emit_f];
    assign emit_back = emit_q0 * TPR_MUL;
    assign emit_r0   = emit_tile - emit_back;
    assign emit_fix  = emit_r0 >= TPR_MUL;
    assign emit_col  = emit_fix ? emit_r0 - TPR_MUL : emit_r0;
    assign emit_row  = emit_q0 + TILE_W'(emit_fix);

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit_go  = (state_reg == ST_EMIT) && (vis_reg != '0) && out_free;

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && (in_req == REQ_MESH) && in_range) begin
                    state_next = ST_CELL;
                end
            end
            ST_CELL: begin
                state_next = ST_DIVX;
            end
            ST_DIVX: begin
                if (cell_rd_reg[TYPE_W-1:0] == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_DIVY_A;
                end
            end
            ST_DIVY_A: begin
                state_next = ST_DIVY_B;
            end
            ST_DIVY_B: begin
                state_next = ST_PROBE;
            end
            ST_PROBE: begin
                if (f_reg == FACE_RIGHT) begin
                    state_next = ST_PROBE_END;
                end
            end
            ST_PROBE_END: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if ((vis_reg == '0) || (emit_go && (vis_rest == '0))) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            vcnt_reg     <= '0;
            pv_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (emit_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (in_accept && (in_req == REQ_CLEAR)) begin
                vcnt_reg <= '0;
            end else if (emit_go) begin
                vcnt_reg <= vcnt_reg + VERT_STEP;
            end

            pv_reg <= (state_reg == ST_PROBE);
        end
    end

    // Cell, divider and probe datapath.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            idx_reg   <= AW'(in_idx);
            div_t_reg <= AW'(in_idx);
        end

        // Reciprocal estimate for x, then for y.
        if ((state_reg == ST_CELL) || (state_reg == ST_DIVY_A)) begin
            div_q_reg <= div_q0;
        end

        // Correction for x; the quotient goes round again for y and z.
        if (state_reg == ST_DIVX) begin
            x_reg         <= div_rem;
            div_t_reg     <= div_quot;
            type_ok_reg   <= 32'(cell_rd_reg[TYPE_W-1:0]) < TYPE_COUNT;
            tile_base_reg <= TAW'(cell_rd_reg[TYPE_W-1:0]) * TAW'(FACE_COUNT);
        end

        if (state_reg == ST_DIVY_B) begin
            y_reg <= div_rem;
            z_reg <= ZW'(div_quot);
            f_reg <= FACE_TOP;
        end

        // Issue one neighbour and one tile read per cycle.
        if (state_reg == ST_PROBE) begin
            pf_reg   <= f_reg;
            pout_reg <= nb_outside;
            f_reg    <= face_t'(f_reg + 3'd1);
        end

        // Collect the reads issued in the previous cycle.
        if (pv_reg) begin
            vis_reg[pf_reg] <= pout_reg || !cell_rd_reg[TYPE_W];
            tile_reg[pf_reg] <= probe_tile;
            tq_reg[pf_reg]   <= probe_prod[TDIV_SH +: TILE_W];
        end

        if (emit_go) begin
            vis_reg <= vis_rest;
        end
    end

    // Output register load.
    always_ff @(posedge aclk) begin
        if (emit_go) begin
            m_x_reg     <= XY_OUT_W'(x_reg);
            m_y_reg     <= XY_OUT_W'(y_reg);
            m_z_reg     <= Z_OUT_W'(z_reg);
            m_face_reg  <= emit_f;
            m_col_reg   <= TCOL_W'(emit_col);
            m_row_reg   <= TCOL_W'(emit_row);
            m_fv_reg    <= vcnt_reg;
            m_tlast_reg <= (vis_rest == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {4'd0, m_fv_reg, m_row_reg, m_col_reg, m_face_reg,
                       m_z_reg, m_y_reg, m_x_reg};

endmodule

`default_nettype wire

@@ sv/vfc_checker.sv @@
// Port-level checker for the voxel face culler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "voxel_face_culler_core_macros.svh"

module vfc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [vfc_pkg::S_TUSER_W-1:0] s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [vfc_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);
    import vfc_pkg::*;

    // Low bits of first_vertex within the result tdata.
    localparam int FV_LSB = 25;

    logic in_acc;
    logic in_is_mesh;
    logic out_acc;

    assign in_acc     = s_tvalid && s_tready;
    assign in_is_mesh = (s_tuser == REQ_MESH);
    assign out_acc    = m_tvalid && m_tready;

    // A stalled face stays put until taken.
    `VFC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result item changed while stalled")

    // Loads and clears finish in the cycle they are taken.
    `VFC_ASSERT_NEXT(a_load_one_cycle, in_acc && !in_is_mesh, s_tready, "input not ready after a load or clear item")

    // Once a face that is not the cell's last is taken, the next face follows at once.
    `VFC_ASSERT_NEXT(a_next_face, out_acc && !m_tlast, m_tvalid, "gap in the middle of a cell's faces")

    // Each face claims four vertices, so the first index is a multiple of four.
    `VFC_ASSERT_NOW(a_vertex_align, m_tvalid, m_tdata[FV_LSB +: 2] == 2'b00, "first_vertex not a multiple of four")

endmodule

bind voxel_face_culler_core vfc_checker u_vfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
